// ----- design/pvt_pkg.sv -----
// ----------------------------------------------------------------------------
// pvt_pkg
// Shared types, constants and helpers for the perspective vertex transform.
// ----------------------------------------------------------------------------
package pvt_pkg;

    localparam int VIEWPORT_W   = 1000;
    localparam int SW_W         = $clog2(VIEWPORT_W + 1) + 1;
    localparam int COORD_W      = 32;
    localparam int CFG_W        = 64;
    localparam int NUM_CFG      = 8;
    localparam int CFG_IDX_W    = $clog2(NUM_CFG);
    localparam int FRAC_W       = 16;
    localparam int ONE_Q16      = 65536;
    localparam int CLIP_W       = 49;
    localparam int SAT_IN_W     = 66;
    localparam int DIV_BITS     = 32;
    localparam int DIV_STEP     = 4;
    localparam int DIV_STAGES   = DIV_BITS / DIV_STEP;
    // view (2) + projection (1) + divider (prep, steps, fix-up) + screen (2)
    localparam int LATENCY      = 2 + 1 + (DIV_STAGES + 2) + 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [CLIP_W-1:0]  clip_t;

    localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
    localparam coord_t COORD_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VIEW_ROW0_AB = 3'd0,
        CFG_VIEW_ROW0_CT = 3'd1,
        CFG_VIEW_ROW1_AB = 3'd2,
        CFG_VIEW_ROW1_CT = 3'd3,
        CFG_VIEW_ROW2_AB = 3'd4,
        CFG_VIEW_ROW2_CT = 3'd5,
        CFG_PROJ_XY      = 3'd6,
        CFG_PROJ_DEPTH   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        coord_t m0;
        coord_t m1;
        coord_t m2;
        coord_t t;
    } view_row_t;

    typedef struct packed {
        coord_t sx;
        coord_t sy;
        coord_t dz;
        coord_t doff;
    } proj_cfg_t;

    // Side information that travels with a division through the divider.
    typedef struct packed {
        logic neg;
        logic zw;
        logic over;
        logic cpos;
        logic cneg;
    } div_flags_t;

    function automatic coord_t sat_coord(input logic signed [SAT_IN_W-1:0] v);
        coord_t res;
        if (v > SAT_IN_W'(COORD_MAX))
            res = COORD_MAX;
        else if (v < SAT_IN_W'(COORD_MIN))
            res = COORD_MIN;
        else
            res = v[COORD_W-1:0];
        return res;
    endfunction

endpackage

// ----- design/pvt_view.sv -----
// ----------------------------------------------------------------------------
// pvt_view
// View matrix: nine products in one stage, row sums and saturation in the next.
// ----------------------------------------------------------------------------
module pvt_view (
    input  logic               aclk,
    input  logic               en_i,
    input  pvt_pkg::coord_t    x_i,
    input  pvt_pkg::coord_t    y_i,
    input  pvt_pkg::coord_t    z_i,
    input  pvt_pkg::view_row_t row_i [3],
    output pvt_pkg::coord_t    v_o   [3]
);
    import pvt_pkg::*;

    logic signed [63:0] prod_reg [3][3];
    coord_t             t_reg    [3];
    coord_t             v_reg    [3];
    coord_t             v_next   [3];

    always_ff @(posedge aclk) begin
        if (en_i) begin
            for (int r = 0; r < 3; r++) begin
                prod_reg[r][0] <= 64'(row_i[r].m0) * 64'(x_i);
                prod_reg[r][1] <= 64'(row_i[r].m1) * 64'(y_i);
                prod_reg[r][2] <= 64'(row_i[r].m2) * 64'(z_i);
                t_reg[r]       <= row_i[r].t;
            end
        end
    end

    always_comb begin
        logic signed [SAT_IN_W-1:0] acc;
        for (int r = 0; r < 3; r++) begin
            acc = SAT_IN_W'(prod_reg[r][0]) + SAT_IN_W'(prod_reg[r][1])
                + SAT_IN_W'(prod_reg[r][2]);
            acc = (acc >>> FRAC_W) + SAT_IN_W'(t_reg[r]);
            v_next[r] = sat_coord(acc);
        end
    end

    always_ff @(posedge aclk) begin
        if (en_i) begin
            v_reg <= v_next;
        end
    end

    assign v_o = v_reg;

endmodule

// ----- design/pvt_proj.sv -----
// ----------------------------------------------------------------------------
// pvt_proj
// Sparse projection: scale x and y, scale and offset depth, pass w along.
// ----------------------------------------------------------------------------
module pvt_proj (
    input  logic               aclk,
    input  logic               en_i,
    input  pvt_pkg::coord_t    v_i [3],
    input  pvt_pkg::proj_cfg_t proj_i,
    output pvt_pkg::clip_t     cx_o,
    output pvt_pkg::clip_t     cy_o,
    output pvt_pkg::clip_t     cz_o,
    output pvt_pkg::coord_t    w_o
);
    import pvt_pkg::*;

    clip_t  cx_reg, cy_reg, cz_reg;
    coord_t w_reg;

    always_ff @(posedge aclk) begin
        logic signed [63:0] px, py, pz;
        px = 64'(proj_i.sx) * 64'(v_i[0]);
        py = 64'(proj_i.sy) * 64'(v_i[1]);
        pz = 64'(proj_i.dz) * 64'(v_i[2]);
        if (en_i) begin
            cx_reg <= CLIP_W'(px >>> FRAC_W);
            cy_reg <= CLIP_W'(py >>> FRAC_W);
            cz_reg <= CLIP_W'(pz >>> FRAC_W) + CLIP_W'(proj_i.doff);
            w_reg  <= v_i[2];
        end
    end

    assign cx_o = cx_reg;
    assign cy_o = cy_reg;
    assign cz_o = cz_reg;
    assign w_o  = w_reg;

endmodule

// ----- design/pvt_div.sv -----
// ----------------------------------------------------------------------------
// pvt_div
// Pipelined restoring divider: ndc = clip * 2^16 / w, truncated, saturated.
// ----------------------------------------------------------------------------
module pvt_div (
    input  logic            aclk,
    input  logic            en_i,
    input  pvt_pkg::clip_t  clip_i,
    input  pvt_pkg::coord_t w_i,
    output pvt_pkg::coord_t ndc_o,
    output logic            zero_o
);
    import pvt_pkg::*;

    logic [DIV_BITS-1:0] r_reg    [DIV_STAGES+1];
    logic [DIV_BITS-1:0] low_reg  [DIV_STAGES+1];
    logic [DIV_BITS-1:0] q_reg    [DIV_STAGES+1];
    logic [COORD_W-1:0]  den_reg  [DIV_STAGES+1];
    div_flags_t          flag_reg [DIV_STAGES+1];
    coord_t              ndc_reg;
    logic                zero_reg;

    // Prep: magnitudes, signs, and the overflow check (quotient >= 2^32).
    always_ff @(posedge aclk) begin
        logic [CLIP_W-1:0]  mag;
        logic [COORD_W-1:0] den;
        mag = clip_i[CLIP_W-1] ? CLIP_W'(-clip_i) : CLIP_W'(clip_i);
        den = w_i[COORD_W-1] ? COORD_W'(-w_i) : COORD_W'(w_i);
        if (en_i) begin
            r_reg[0]         <= mag[CLIP_W-2:FRAC_W];
            low_reg[0]       <= {mag[FRAC_W-1:0], {FRAC_W{1'b0}}};
            q_reg[0]         <= '0;
            den_reg[0]       <= den;
            flag_reg[0].neg  <= clip_i[CLIP_W-1] ^ w_i[COORD_W-1];
            flag_reg[0].zw   <= (w_i == '0);
            flag_reg[0].over <= ({1'b0, mag[CLIP_W-1:FRAC_W]} >= {2'b00, den});
            flag_reg[0].cpos <= !clip_i[CLIP_W-1] && (clip_i != '0);
            flag_reg[0].cneg <= clip_i[CLIP_W-1];
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
        logic [DIV_BITS-1:0] r_next, low_next, q_next;

        always_comb begin
            logic [DIV_BITS:0] trial;
            r_next   = r_reg[k];
            low_next = low_reg[k];
            q_next   = q_reg[k];
            for (int j = 0; j < DIV_STEP; j++) begin
                trial    = {r_next, low_next[DIV_BITS-1]};
                low_next = {low_next[DIV_BITS-2:0], 1'b0};
                if (trial >= {1'b0, den_reg[k]}) begin
                    trial  = trial - {1'b0, den_reg[k]};
                    q_next = {q_next[DIV_BITS-2:0], 1'b1};
                end else begin
                    q_next = {q_next[DIV_BITS-2:0], 1'b0};
                end
                r_next = trial[DIV_BITS-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (en_i) begin
                r_reg[k+1]    <= r_next;
                low_reg[k+1]  <= low_next;
                q_reg[k+1]    <= q_next;
                den_reg[k+1]  <= den_reg[k];
                flag_reg[k+1] <= flag_reg[k];
            end
        end
    end

    // Fix-up: apply sign, saturate, handle zero w.
    always_ff @(posedge aclk) begin
        logic [DIV_BITS-1:0] q;
        div_flags_t          f;
        q = q_reg[DIV_STAGES];
        f = flag_reg[DIV_STAGES];
        if (en_i) begin
            zero_reg <= f.zw;
            if (f.zw)
                ndc_reg <= f.cpos ? COORD_MAX : (f.cneg ? COORD_MIN : '0);
            else if (f.over)
                ndc_reg <= f.neg ? COORD_MIN : COORD_MAX;
            else if (f.neg)
                ndc_reg <= (q > DIV_BITS'(COORD_MIN)) ? COORD_MIN : coord_t'(-q);
            else
                ndc_reg <= (q > DIV_BITS'(COORD_MAX)) ? COORD_MAX : coord_t'(q);
        end
    end

    assign ndc_o  = ndc_reg;
    assign zero_o = zero_reg;

endmodule

// ----- design/pvt_screen.sv -----
// ----------------------------------------------------------------------------
// pvt_screen
// Screen mapping (ndc + 1) * width / 2, floored and saturated, in two stages.
// ----------------------------------------------------------------------------
module pvt_screen (
    input  logic            aclk,
    input  logic            en_i,
    input  pvt_pkg::coord_t ndc_x_i,
    input  pvt_pkg::coord_t ndc_y_i,
    input  pvt_pkg::coord_t ndc_z_i,
    input  logic            zero_i,
    output pvt_pkg::coord_t scr_x_o,
    output pvt_pkg::coord_t scr_y_o,
    output pvt_pkg::coord_t ndc_z_o,
    output logic            zero_o
);
    import pvt_pkg::*;

    localparam int PW = COORD_W + 1 + SW_W;

    logic signed [PW-1:0] px_reg, py_reg;
    coord_t               nz_reg, nz_out_reg, sx_reg, sy_reg;
    logic                 zw_reg, zw_out_reg;

    always_ff @(posedge aclk) begin
        if (en_i) begin
            px_reg     <= (PW'(ndc_x_i) + PW'(ONE_Q16)) * PW'(VIEWPORT_W);
            py_reg     <= (PW'(ndc_y_i) + PW'(ONE_Q16)) * PW'(VIEWPORT_W);
            nz_reg     <= ndc_z_i;
            zw_reg     <= zero_i;
            sx_reg     <= sat_coord(SAT_IN_W'(px_reg >>> 1));
            sy_reg     <= sat_coord(SAT_IN_W'(py_reg >>> 1));
            nz_out_reg <= nz_reg;
            zw_out_reg <= zw_reg;
        end
    end

    assign scr_x_o = sx_reg;
    assign scr_y_o = sy_reg;
    assign ndc_z_o = nz_out_reg;
    assign zero_o  = zw_out_reg;

endmodule

// ----- design/perspective_vertex_transform.sv -----
// ----------------------------------------------------------------------------
// perspective_vertex_transform
// View transform, sparse projection, perspective divide and screen mapping
// of one Q16.16 point per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
//  channel   direction  handshake         payload
//  s_        in         s_tvalid/tready   tdata: point_x, point_y, point_z
//  m_        out        m_tvalid/tready   tdata: screen_x, screen_y, ndc_depth
//                                         tuser: zero_w
//  cfg_      in         cfg_wr_en         cfg_index, cfg_wdata (64 bits)
//
// One point enters per cycle unless the output stalls; each result passes through
// two view stages, one projection stage, the divider (prep, eight 4-bit
// quotient stages, fix-up) and two screen stages.
// Reset clears the valid bits and the configuration registers.
// A stall at the output freezes the whole pipeline; s_tready drops with it.
// ----------------------------------------------------------------------------
module perspective_vertex_transform (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [95:0]                    s_tdata,  // point_x, point_y, point_z
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [95:0]                    m_tdata,  // screen_x, screen_y, ndc_depth
    output logic                           m_tuser,  // zero_w
    input  logic                           cfg_wr_en,
    input  logic [pvt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pvt_pkg::CFG_W-1:0]      cfg_wdata
);
    import pvt_pkg::*;

    logic [CFG_W-1:0] cfg_reg   [NUM_CFG];
    logic [LATENCY-1:0] valid_reg, valid_next;
    logic             adv;

    view_row_t rows [3];
    proj_cfg_t proj;
    coord_t    v [3];
    clip_t     cx, cy, cz;
    coord_t    w;
    coord_t    nx, ny, nz;
    logic      zw;
    coord_t    scr_x, scr_y, ndc_z;
    logic      zw_out;

    // Configuration: write the addressed register, no read-back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CFG; i++) cfg_reg[i] <= '0;
        end else if (cfg_wr_en) begin
            cfg_reg[cfg_index] <= cfg_wdata;
        end
    end

    // Unpack the rows: low half first, high half second.
    always_comb begin
        rows[0] = '{m0: cfg_reg[CFG_VIEW_ROW0_AB][31:0], m1: cfg_reg[CFG_VIEW_ROW0_AB][63:32],
                    m2: cfg_reg[CFG_VIEW_ROW0_CT][31:0], t:  cfg_reg[CFG_VIEW_ROW0_CT][63:32]};
        rows[1] = '{m0: cfg_reg[CFG_VIEW_ROW1_AB][31:0], m1: cfg_reg[CFG_VIEW_ROW1_AB][63:32],
                    m2: cfg_reg[CFG_VIEW_ROW1_CT][31:0], t:  cfg_reg[CFG_VIEW_ROW1_CT][63:32]};
        rows[2] = '{m0: cfg_reg[CFG_VIEW_ROW2_AB][31:0], m1: cfg_reg[CFG_VIEW_ROW2_AB][63:32],
                    m2: cfg_reg[CFG_VIEW_ROW2_CT][31:0], t:  cfg_reg[CFG_VIEW_ROW2_CT][63:32]};
        proj    = '{sx: cfg_reg[CFG_PROJ_XY][31:0],    sy:   cfg_reg[CFG_PROJ_XY][63:32],
                    dz: cfg_reg[CFG_PROJ_DEPTH][31:0], doff: cfg_reg[CFG_PROJ_DEPTH][63:32]};
    end

    // Advance when the output register is empty or being drained.
    assign adv      = !valid_reg[LATENCY-1] || m_tready;
    assign s_tready = adv;

    // Valid bits travel alongside the data stages.
    assign valid_next = {valid_reg[LATENCY-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    pvt_view u_view (
        .aclk  (aclk),
        .en_i  (adv),
        .x_i   (s_tdata[31:0]),
        .y_i   (s_tdata[63:32]),
        .z_i   (s_tdata[95:64]),
        .row_i (rows),
        .v_o   (v)
    );

    pvt_proj u_proj (
        .aclk   (aclk),
        .en_i   (adv),
        .v_i    (v),
        .proj_i (proj),
        .cx_o   (cx),
        .cy_o   (cy),
        .cz_o   (cz),
        .w_o    (w)
    );

    pvt_div u_div_x (
        .aclk   (aclk),
        .en_i   (adv),
        .clip_i (cx),
        .w_i    (w),
        .ndc_o  (nx),
        .zero_o ()
    );

    pvt_div u_div_y (
        .aclk   (aclk),
        .en_i   (adv),
        .clip_i (cy),
        .w_i    (w),
        .ndc_o  (ny),
        .zero_o ()
    );

    pvt_div u_div_z (
        .aclk   (aclk),
        .en_i   (adv),
        .clip_i (cz),
        .w_i    (w),
        .ndc_o  (nz),
        .zero_o (zw)
    );

    pvt_screen u_screen (
        .aclk    (aclk),
        .en_i    (adv),
        .ndc_x_i (nx),
        .ndc_y_i (ny),
        .ndc_z_i (nz),
        .zero_i  (zw),
        .scr_x_o (scr_x),
        .scr_y_o (scr_y),
        .ndc_z_o (ndc_z),
        .zero_o  (zw_out)
    );

    assign m_tvalid = valid_reg[LATENCY-1];
    assign m_tdata  = {ndc_z, scr_y, scr_x};
    assign m_tuser  = zw_out;

    // Zero w leaves only the saturated or zero depth.
    a_zero_w_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            (ndc_z == COORD_MAX || ndc_z == COORD_MIN || ndc_z == '0))
        else $error("zero_w result with unsaturated depth");

    // Input side takes requests exactly when the pipeline advances.
    a_ready_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready out of step with output stall");

    // No result right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

endmodule

// ----- bench/tb_perspective_vertex_transform.sv -----
// ----------------------------------------------------------------------------
// tb_perspective_vertex_transform
// Streams Q16.16 points through the vertex transform and compares each
// screen/depth result with a predictor built from exact wide arithmetic.
// The bench walks several matrix settings, rewriting them while the pipe is idle.
// ----------------------------------------------------------------------------
module tb_perspective_vertex_transform;
    timeunit 1ns;
    timeprecision 1ps;
    import pvt_pkg::*;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] nz;
        logic               zw;
    } vtx_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // point_x, point_y, point_z
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;   // screen_x, screen_y, ndc_depth
    logic        m_tuser;   // zero_w
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    perspective_vertex_transform DUT (.*);

    // Current setting copy used by the predictor.
    logic [63:0] mat_regs [NUM_CFG];

    logic [95:0]  point_queue [$];
    vtx_result_t  screen_queue [$];

    int  mismatches;
    int  idle_cycles;
    bit  stall_hold;       // long receiver hold-off request
    int  burst_left;
    int  gap_left;
    bit  sender_pause;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic signed [127:0] floor_div16(input logic signed [127:0] v);
        return v >>> 16;
    endfunction

    function automatic logic signed [127:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return 128'sd2147483647;
        if (v < -128'sd2147483648) return -128'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [127:0] lo_of(input logic [63:0] r);
        return 128'(signed'(r[31:0]));
    endfunction

    function automatic logic signed [127:0] hi_of(input logic [63:0] r);
        return 128'(signed'(r[63:32]));
    endfunction

    function automatic logic signed [127:0] view_axis(input int row,
            input logic signed [127:0] x, y, z);
        logic signed [127:0] acc;
        acc = lo_of(mat_regs[2*row]) * x + hi_of(mat_regs[2*row]) * y
            + lo_of(mat_regs[2*row+1]) * z;
        return clamp32(floor_div16(acc) + hi_of(mat_regs[2*row+1]));
    endfunction

    // Divide truncating toward zero; a zero w saturates by the clip sign.
    function automatic logic signed [127:0] ndc_divide(input logic signed [127:0] c, w);
        logic signed [127:0] mag, den, q;
        if (w == 0) begin
            if (c > 0) return 128'sd2147483647;
            if (c < 0) return -128'sd2147483648;
            return 0;
        end
        mag = (c < 0) ? -c : c;
        den = (w < 0) ? -w : w;
        q = (mag <<< 16) / den;
        if ((c < 0) != (w < 0)) q = -q;
        return clamp32(q);
    endfunction

    function automatic logic signed [127:0] screen_map(input logic signed [127:0] n);
        return clamp32(((n + ONE_Q16) * VIEWPORT_W) >>> 1);
    endfunction

    function automatic vtx_result_t project_point(input logic [95:0] p);
        logic signed [127:0] x, y, z, vx, vy, vz, cx, cy, cz;
        vtx_result_t r;
        x = 128'(signed'(p[31:0]));
        y = 128'(signed'(p[63:32]));
        z = 128'(signed'(p[95:64]));
        vx = view_axis(0, x, y, z);
        vy = view_axis(1, x, y, z);
        vz = view_axis(2, x, y, z);
        cx = floor_div16(lo_of(mat_regs[CFG_PROJ_XY]) * vx);
        cy = floor_div16(hi_of(mat_regs[CFG_PROJ_XY]) * vy);
        cz = floor_div16(lo_of(mat_regs[CFG_PROJ_DEPTH]) * vz) + hi_of(mat_regs[CFG_PROJ_DEPTH]);
        r.sx = 32'(screen_map(ndc_divide(cx, vz)));
        r.sy = 32'(screen_map(ndc_divide(cy, vz)));
        r.nz = 32'(ndc_divide(cz, vz));
        r.zw = (vz == 0);
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 2) == 0 ? 32'h0 : 32'(int'($urandom_range(0, 20)) - 10);
            3: return 32'(int'($urandom_range(0, 40 << 16)) - (20 << 16));
            default: return $urandom;
        endcase
    endfunction

    // Driver: bursts of offered requests separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                screen_queue.push_back(project_point(s_tdata));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || sender_pause || point_queue.size() == 0) begin
                    s_tvalid <= 1'b0;
                    if (gap_left > 0) gap_left <= gap_left - 1;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= point_queue.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // Monitor: compare each result request with the oldest prediction.
    always @(posedge aclk) begin
        vtx_result_t want, got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser};
                if (screen_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    want = screen_queue.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch sx %h/%h sy %h/%h nz %h/%h zw %b/%b",
                                want.sx, got.sx, want.sy, got.sy, want.nz, got.nz,
                                want.zw, got.zw);
                    end
                end
            end
            // stall pattern: mostly ready, with random stalls
            m_tready <= !stall_hold && ($urandom_range(0, 99) < 75);
        end
    end

    // Watchdog: count cycles with no request moving.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 5000) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        mat_regs[idx] = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold until the pipe has drained.
    task automatic drain();
        while (point_queue.size() != 0 || s_tvalid || screen_queue.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [63:0] pack2(input int lo, input int hi);
        return {32'(hi), 32'(lo)};
    endfunction

    initial begin
        int phase;
        mismatches = 0;
        stall_hold = 1'b0;
        sender_pause = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        for (int i = 0; i < NUM_CFG; i++) mat_regs[i] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values: all zero, so every point hits the zero-w case.
        point_queue.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h0});
        drain();

        // Identity-like setting: w = z, so zero and negative z are both met.
        write_reg(CFG_VIEW_ROW0_AB, pack2(ONE_Q16, 0));
        write_reg(CFG_VIEW_ROW0_CT, pack2(0, 0));
        write_reg(CFG_VIEW_ROW1_AB, pack2(0, ONE_Q16));
        write_reg(CFG_VIEW_ROW1_CT, pack2(0, 0));
        write_reg(CFG_VIEW_ROW2_AB, pack2(0, 0));
        write_reg(CFG_VIEW_ROW2_CT, pack2(ONE_Q16, 0));
        write_reg(CFG_PROJ_XY, pack2(ONE_Q16, ONE_Q16));
        write_reg(CFG_PROJ_DEPTH, pack2(ONE_Q16, -ONE_Q16));
        point_queue.push_back({32'h0001_0000, 32'h0000_8000, 32'hFFFF_8000});
        point_queue.push_back({32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000});
        point_queue.push_back({32'h0000_0000, 32'h0001_0000, 32'h0000_0000});
        point_queue.push_back({32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
        point_queue.push_back({32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000});
        point_queue.push_back({32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
        point_queue.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        point_queue.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        point_queue.push_back({32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF});
        drain();

        for (phase = 0; phase < 8; phase++) begin
            // Extremes in some phases, small random matrices in others.
            for (int r = 0; r < NUM_CFG; r++) begin
                logic [63:0] v;
                case (phase % 4)
                    0: v = {$urandom, $urandom};
                    1: v = (r % 2) ? 64'h8000_0000_7FFF_FFFF : 64'h7FFF_FFFF_8000_0000;
                    default: v = pack2(int'($urandom_range(0, 4 << 16)) - (2 << 16),
                                       int'($urandom_range(0, 4 << 16)) - (2 << 16));
                endcase
                write_reg(cfg_idx_t'(r), v);
            end
            for (int k = 0; k < 210; k++)
                point_queue.push_back({rand_coord(), rand_coord(), rand_coord()});
            if (phase == 2) begin
                // long receiver hold-off while the sender keeps offering
                stall_hold = 1'b1;
                repeat (300) @(posedge aclk);
                stall_hold = 1'b0;
            end
            if (phase == 5) begin
                // sender pauses until every pending result is back
                repeat (50) @(posedge aclk);
                sender_pause = 1'b1;
                while (screen_queue.size() != 0 || s_tvalid) @(posedge aclk);
                sender_pause = 1'b0;
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
